/* rtl/core/xalu_pkg.sv */
// shared types and constants of the 16-bit execute unit with flags
// operation codes, flag bit positions and the execute result bundle
// no dependencies
package xalu_pkg;

	localparam int unsigned DataW = 16;
	localparam int unsigned ModeW = 4;

	typedef enum logic [ModeW-1:0] {
		MODE_ADC = 4'd0,
		MODE_AND = 4'd1,
		MODE_CMP = 4'd2,
		MODE_AAA = 4'd3,
		MODE_AAS = 4'd4,
		MODE_AAD = 4'd5,
		MODE_AAM = 4'd6,
		MODE_CBW = 4'd7,
		MODE_STC = 4'd8,
		MODE_CLC = 4'd9,
		MODE_CMC = 4'd10,
		MODE_STD = 4'd11,
		MODE_CLD = 4'd12,
		MODE_STI = 4'd13,
		MODE_CLI = 4'd14
	} mode_t;

	// flag bit positions in the flags word
	localparam int unsigned FL_CF = 0;
	localparam int unsigned FL_PF = 2;
	localparam int unsigned FL_AF = 4;
	localparam int unsigned FL_ZF = 6;
	localparam int unsigned FL_SF = 7;
	localparam int unsigned FL_IF = 9;
	localparam int unsigned FL_DF = 10;
	localparam int unsigned FL_OF = 11;

	// decimal adjust constants
	localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
	localparam logic [7:0] BCD_ADJ = 8'd6;
	// x / 10 == (x * 205) >> 11 for every 8-bit x
	localparam logic [7:0] DIV10_MUL = 8'd205;
	localparam int unsigned DIV10_SHIFT = 11;

	typedef struct packed {
		logic [DataW-1:0] result;
		logic             write_back;
		logic [DataW-1:0] flags;
	} exec_res_t;

endpackage

/* rtl/core/xalu_in_if.sv */
// input channel of the execute unit: valid/ready with operation and operands
// depends on xalu_pkg for widths
interface xalu_in_if;
	logic                          valid;
	logic                          ready;
	logic [xalu_pkg::ModeW-1:0]    mode;
	logic [xalu_pkg::DataW-1:0]    dest_value;
	logic [xalu_pkg::DataW-1:0]    src_value;

	modport source (output valid, mode, dest_value, src_value, input ready);
	modport sink (input valid, mode, dest_value, src_value, output ready);
endinterface

/* rtl/core/xalu_out_if.sv */
// output channel of the execute unit: valid/ready with result and flags
// depends on xalu_pkg for widths
interface xalu_out_if;
	logic                          valid;
	logic                          ready;
	logic [xalu_pkg::DataW-1:0]    result;
	logic                          write_back;
	logic [xalu_pkg::DataW-1:0]    flags_out;

	modport source (output valid, result, write_back, flags_out, input ready);
	modport sink (input valid, result, write_back, flags_out, output ready);
endinterface

/* rtl/core/xalu_exec.sv */
// combinational execute logic: one operation against the current flags
// depends on xalu_pkg
module xalu_exec (
	input  logic [xalu_pkg::ModeW-1:0] mode,
	input  logic [xalu_pkg::DataW-1:0] dest_value,
	input  logic [xalu_pkg::DataW-1:0] src_value,
	input  logic [xalu_pkg::DataW-1:0] flags_in,
	output xalu_pkg::exec_res_t        res
);
	import xalu_pkg::*;

	logic [DataW:0]   sum;
	logic [DataW:0]   diff;
	logic [DataW-1:0] and_r;
	logic [7:0]       al;
	logic [7:0]       ah;
	logic             bcd_adj;
	logic [7:0]       aad_r;
	logic [15:0]      div_prod;
	logic [7:0]       aam_q;
	logic [7:0]       aam_r;
	logic [DataW-1:0] szp_val;
	logic             szp_en;
	logic [DataW-1:0] fl;
	logic [DataW-1:0] r;
	logic             wb;

	assign al = dest_value[7:0];
	assign ah = dest_value[15:8];

	assign sum = {1'b0, dest_value} + {1'b0, src_value} + {{DataW{1'b0}}, flags_in[FL_CF]};
	assign diff = {1'b0, dest_value} - {1'b0, src_value};
	assign and_r = dest_value & src_value;

	assign bcd_adj = (al[3:0] > BCD_MAX_DIGIT) || flags_in[FL_AF];

	// al + ah * 10 modulo 256, as shifts
	assign aad_r = al + {ah[4:0], 3'b000} + {ah[6:0], 1'b0};

	// divide by ten through the reciprocal multiply
	assign div_prod = al * DIV10_MUL;
	assign aam_q = 8'(div_prod >> DIV10_SHIFT);
	assign aam_r = al - ({aam_q[4:0], 3'b000} + {aam_q[6:0], 1'b0});

	always_comb begin
		fl = flags_in;
		r = '0;
		wb = 1'b0;
		szp_val = '0;
		szp_en = 1'b0;
		case (mode_t'(mode))
			MODE_ADC: begin
				r = sum[DataW-1:0];
				wb = 1'b1;
				fl[FL_CF] = sum[DataW];
				fl[FL_AF] = dest_value[4] ^ src_value[4] ^ sum[4];
				fl[FL_OF] = (dest_value[15] ^ sum[15]) & (src_value[15] ^ sum[15]);
				szp_val = sum[DataW-1:0];
				szp_en = 1'b1;
			end
			MODE_AND: begin
				r = and_r;
				wb = 1'b1;
				fl[FL_CF] = 1'b0;
				fl[FL_OF] = 1'b0;
				szp_val = and_r;
				szp_en = 1'b1;
			end
			MODE_CMP: begin
				r = diff[DataW-1:0];
				fl[FL_CF] = diff[DataW];
				fl[FL_AF] = dest_value[4] ^ src_value[4] ^ diff[4];
				fl[FL_OF] = (dest_value[15] ^ src_value[15]) & (dest_value[15] ^ diff[15]);
				szp_val = diff[DataW-1:0];
				szp_en = 1'b1;
			end
			MODE_AAA: begin
				wb = 1'b1;
				fl[FL_AF] = bcd_adj;
				fl[FL_CF] = bcd_adj;
				if (bcd_adj) begin
					r = {ah + 8'd1, 4'b0000, 4'(al + BCD_ADJ)};
				end else begin
					r = {ah, 4'b0000, al[3:0]};
				end
			end
			MODE_AAS: begin
				wb = 1'b1;
				fl[FL_AF] = bcd_adj;
				fl[FL_CF] = bcd_adj;
				if (bcd_adj) begin
					r = {ah - 8'd1, 4'b0000, 4'(al - BCD_ADJ)};
				end else begin
					r = {ah, 4'b0000, al[3:0]};
				end
			end
			MODE_AAD: begin
				wb = 1'b1;
				r = {8'h00, aad_r};
			end
			MODE_AAM: begin
				wb = 1'b1;
				r = {aam_q, aam_r};
			end
			MODE_CBW: begin
				wb = 1'b1;
				r = {{8{al[7]}}, al};
			end
			MODE_STC: fl[FL_CF] = 1'b1;
			MODE_CLC: fl[FL_CF] = 1'b0;
			MODE_CMC: fl[FL_CF] = ~flags_in[FL_CF];
			MODE_STD: fl[FL_DF] = 1'b1;
			MODE_CLD: fl[FL_DF] = 1'b0;
			MODE_STI: fl[FL_IF] = 1'b1;
			MODE_CLI: fl[FL_IF] = 1'b0;
			default: begin
			end
		endcase
		if (szp_en) begin
			fl[FL_SF] = szp_val[DataW-1];
			fl[FL_ZF] = (szp_val == '0);
			fl[FL_PF] = ~^szp_val[7:0];
		end
		res.result = r;
		res.write_back = wb;
		res.flags = fl;
	end

endmodule

/* rtl/core/x86_16bit_alu_with_flags_unit.sv */
// top level of the 16-bit execute unit with flags register
// depends on xalu_pkg, xalu_in_if, xalu_out_if and xalu_exec
//
// usage
// - in_ch carries one operation per transfer: mode, dest_value (AX for the
//   decimal adjusts and cbw) and src_value
// - out_ch returns exactly one transfer per input transfer, in order: result,
//   write_back mark and the flags word as it stands after the operation
// - path: the item is captured in an input register, executed against the
//   flags register and the outcome is captured in the result register
// - throughput: one item per cycle while out_ch.ready stays high; the only
//   loop is the flags register, which is updated in the same cycle the item
//   leaves the input register
// - stall: when the receiver holds ready low the result register keeps its
//   transfer, the input register fills, and in_ch.ready drops only once both
//   are occupied; nothing is lost or repeated
// - reset: arst_n clears both valid bits and the flags register to zero
module x86_16bit_alu_with_flags_unit (
	input logic        clk,
	input logic        arst_n,
	xalu_in_if.sink    in_ch,
	xalu_out_if.source out_ch
);
	import xalu_pkg::*;

	// input register stage
	logic                valid_s1;
	logic [ModeW-1:0]    mode_s1;
	logic [DataW-1:0]    dest_s1;
	logic [DataW-1:0]    src_s1;

	// result register stage
	logic                valid_s2;
	exec_res_t           res_s2;

	// architectural flags
	logic [DataW-1:0]    flags_q;

	exec_res_t           exec_res;
	logic                s2_free;
	logic                s1_move;

	// result register can take a new item when empty or draining this cycle
	assign s2_free = !valid_s2 || out_ch.ready;
	assign s1_move = valid_s1 && s2_free;
	assign in_ch.ready = !valid_s1 || s2_free;

	xalu_exec u_exec (
		.mode       (mode_s1),
		.dest_value (dest_s1),
		.src_value  (src_s1),
		.flags_in   (flags_q),
		.res        (exec_res)
	);

	// control: valid bits and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q <= '0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			// flags commit when the item leaves the input register
			if (s1_move) begin
				flags_q <= exec_res.flags;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			mode_s1 <= in_ch.mode;
			dest_s1 <= in_ch.dest_value;
			src_s1 <= in_ch.src_value;
		end
		if (s1_move) begin
			res_s2 <= exec_res;
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.result = res_s2.result;
	assign out_ch.write_back = res_s2.write_back;
	assign out_ch.flags_out = res_s2.flags;

endmodule
